### sv/page_frame_allocator_defines.svh
// Assertion macros shared by the page-frame allocator RTL.
`ifndef PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define PAGE_FRAME_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define PFA_ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define PFA_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define PFA_ASSERT_PROP(lbl, prop, msg)
`define PFA_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

### sv/pfa_pkg.sv
// Shared types, constants and codes of the page-frame allocator.
package pfa_pkg;

    localparam int NUM_PAGES = 32768;
    localparam int REF_WIDTH = 16;

    localparam int PAGE_W = $clog2(NUM_PAGES);
    localparam int LINK_W = $clog2(NUM_PAGES + 1);
    localparam int CFG_W  = 16;
    localparam int CNT_W  = (PAGE_W + 1 > CFG_W) ? PAGE_W + 1 : CFG_W;
    localparam int REQ_W  = 3;
    localparam int PNUM_W = 15;
    localparam int STAT_W = 3;
    localparam int REFO_W = 16;
    localparam int CIDX_W = 3;

    typedef logic [PAGE_W-1:0]    t_page;
    typedef logic [LINK_W-1:0]    t_link;
    typedef logic [REF_WIDTH-1:0] t_ref;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [CFG_W-1:0]     t_cfg;
    typedef logic [PNUM_W-1:0]    t_pnum;
    typedef logic [REFO_W-1:0]    t_refo;
    typedef logic [REQ_W-1:0]     t_req;
    typedef logic [STAT_W-1:0]    t_status;
    typedef logic [CIDX_W-1:0]    t_cfg_idx;

    localparam t_link LINK_NONE  = t_link'(NUM_PAGES);
    localparam t_ref  REF_MAX    = '1;
    localparam t_cnt  CNT_PAGES  = t_cnt'(NUM_PAGES);

    localparam t_req REQ_ALLOC  = 3'd0;
    localparam t_req REQ_FREE   = 3'd1;
    localparam t_req REQ_INCREF = 3'd2;
    localparam t_req REQ_DECREF = 3'd3;
    localparam t_req REQ_INIT   = 3'd4;

    localparam t_status STAT_OK          = 3'd0;
    localparam t_status STAT_NONE_FREE   = 3'd1;
    localparam t_status STAT_REF_NONZERO = 3'd2;
    localparam t_status STAT_LISTED      = 3'd3;
    localparam t_status STAT_UNDERFLOW   = 3'd4;
    localparam t_status STAT_FREED       = 3'd5;
    localparam t_status STAT_SATURATED   = 3'd6;

    localparam t_cfg_idx CFG_BASE_PAGES     = 3'd0;
    localparam t_cfg_idx CFG_IO_HOLE_START  = 3'd1;
    localparam t_cfg_idx CFG_EXT_START      = 3'd2;
    localparam t_cfg_idx CFG_FIRST_FREE_EXT = 3'd3;
    localparam t_cfg_idx CFG_TOTAL_PAGES    = 3'd4;

    localparam t_cfg RST_BASE_PAGES     = 16'd160;
    localparam t_cfg RST_IO_HOLE_START  = 16'd160;
    localparam t_cfg RST_EXT_START      = 16'd256;
    localparam t_cfg RST_FIRST_FREE_EXT = 16'd256;
    localparam t_cfg RST_TOTAL_PAGES    = 16'd32768;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_BASE,
        ST_HOLE,
        ST_EXT
    } t_state;

    typedef enum logic [2:0] {
        WALK_NONE,
        WALK_CLEAR,
        WALK_BASE,
        WALK_HOLE,
        WALK_EXT
    } t_walk;

    typedef enum logic [1:0] {
        CNT_ZERO,
        CNT_ONE,
        CNT_HOLE,
        CNT_EXT
    } t_cnt_sel;

    typedef struct packed {
        logic     accept;
        logic     exec;
        logic     head_clear;
        logic     cnt_load;
        t_cnt_sel cnt_sel;
        t_walk    walk;
        logic     init_ref0;
        logic     init_done;
    } t_dp_cmd;

    typedef struct packed {
        logic walk_end;
    } t_dp_stat;

    typedef struct packed {
        t_req  req_type;
        t_pnum page_num;
        logic  zero_fill;
    } t_in_item;

    typedef struct packed {
        t_status status;
        t_pnum   out_page;
        t_refo   ref_after;
        logic    clear_page;
    } t_out_item;

endpackage

### sv/pfa_ctrl.sv
// Control state machine of the page-frame allocator: request sequencing and init walks.
module pfa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  pfa_pkg::t_req     i_req_type,
    input  pfa_pkg::t_dp_stat i_stat,
    output logic              o_busy,
    output pfa_pkg::t_dp_cmd  o_cmd
);

    pfa_pkg::t_state r_state, n_state;
    logic            r_init, n_init;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfa_pkg::ST_CLEAR;
            r_init  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_init        = r_init;
        o_cmd         = '0;
        o_cmd.walk    = pfa_pkg::WALK_NONE;
        o_cmd.cnt_sel = pfa_pkg::CNT_ZERO;
        unique case (r_state)
            pfa_pkg::ST_CLEAR: begin
                // The same pass serves reset and init; only init marks page 0 reserved.
                o_cmd.walk      = pfa_pkg::WALK_CLEAR;
                o_cmd.init_ref0 = r_init;
                if (i_stat.walk_end) begin
                    if (r_init) begin
                        o_cmd.cnt_load = 1'b1;
                        o_cmd.cnt_sel  = pfa_pkg::CNT_ONE;
                        n_state        = pfa_pkg::ST_BASE;
                    end else begin
                        n_state = pfa_pkg::ST_IDLE;
                    end
                end
            end
            pfa_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_req_type == pfa_pkg::REQ_INIT) begin
                        o_cmd.head_clear = 1'b1;
                        o_cmd.cnt_load   = 1'b1;
                        o_cmd.cnt_sel    = pfa_pkg::CNT_ZERO;
                        n_init           = 1'b1;
                        n_state          = pfa_pkg::ST_CLEAR;
                    end else begin
                        o_cmd.accept = 1'b1;
                        n_state      = pfa_pkg::ST_EXEC;
                    end
                end
            end
            pfa_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = pfa_pkg::ST_IDLE;
            end
            pfa_pkg::ST_BASE: begin
                o_cmd.walk = pfa_pkg::WALK_BASE;
                if (i_stat.walk_end) begin
                    o_cmd.cnt_load = 1'b1;
                    o_cmd.cnt_sel  = pfa_pkg::CNT_HOLE;
                    n_state        = pfa_pkg::ST_HOLE;
                end
            end
            pfa_pkg::ST_HOLE: begin
                o_cmd.walk = pfa_pkg::WALK_HOLE;
                if (i_stat.walk_end) begin
                    o_cmd.cnt_load = 1'b1;
                    o_cmd.cnt_sel  = pfa_pkg::CNT_EXT;
                    n_state        = pfa_pkg::ST_EXT;
                end
            end
            pfa_pkg::ST_EXT: begin
                o_cmd.walk = pfa_pkg::WALK_EXT;
                if (i_stat.walk_end) begin
                    o_cmd.init_done = 1'b1;
                    n_state         = pfa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pfa_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != pfa_pkg::ST_IDLE);

endmodule

### sv/pfa_datapath.sv
// Datapath of the page-frame allocator: count and link tables, list head, walk counter.
module pfa_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pfa_pkg::t_dp_cmd    i_cmd,
    output pfa_pkg::t_dp_stat   o_stat,
    input  pfa_pkg::t_in_item   i_item,
    input  logic                i_cfg_we,
    input  pfa_pkg::t_cfg_idx   i_cfg_idx,
    input  pfa_pkg::t_cfg       i_cfg_data,
    output logic                o_result_valid,
    output pfa_pkg::t_out_item  o_result
);

    function automatic pfa_pkg::t_cnt clip_pages(input pfa_pkg::t_cfg n);
        pfa_pkg::t_cnt v;
        v = pfa_pkg::t_cnt'(n);
        return (v > pfa_pkg::CNT_PAGES) ? pfa_pkg::CNT_PAGES : v;
    endfunction

    pfa_pkg::t_ref  ref_mem  [pfa_pkg::NUM_PAGES];
    pfa_pkg::t_link link_mem [pfa_pkg::NUM_PAGES];

    pfa_pkg::t_cfg r_base_pages, r_io_hole_start, r_ext_start, r_first_free_ext, r_total_pages;

    pfa_pkg::t_link     r_head, n_head;
    pfa_pkg::t_cnt      r_cnt, n_cnt;
    pfa_pkg::t_req      r_req;
    pfa_pkg::t_pnum     r_pnum;
    logic               r_zf;
    pfa_pkg::t_ref      r_ref_rd;
    pfa_pkg::t_link     r_link_rd;
    logic               r_result_valid;
    pfa_pkg::t_out_item r_result, n_result;

    pfa_pkg::t_page rd_addr, cnt_page, exec_page, head_page;
    pfa_pkg::t_cnt  limit;
    logic           walk_end, step, below_ffe, page_in_range, head_empty, linked;

    logic           ref_we, link_we, head_we, res_we;
    pfa_pkg::t_page ref_wa, link_wa;
    pfa_pkg::t_ref  ref_wd;
    pfa_pkg::t_link link_wd;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_pages     <= pfa_pkg::RST_BASE_PAGES;
            r_io_hole_start  <= pfa_pkg::RST_IO_HOLE_START;
            r_ext_start      <= pfa_pkg::RST_EXT_START;
            r_first_free_ext <= pfa_pkg::RST_FIRST_FREE_EXT;
            r_total_pages    <= pfa_pkg::RST_TOTAL_PAGES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pfa_pkg::CFG_BASE_PAGES:     r_base_pages     <= i_cfg_data;
                pfa_pkg::CFG_IO_HOLE_START:  r_io_hole_start  <= i_cfg_data;
                pfa_pkg::CFG_EXT_START:      r_ext_start      <= i_cfg_data;
                pfa_pkg::CFG_FIRST_FREE_EXT: r_first_free_ext <= i_cfg_data;
                pfa_pkg::CFG_TOTAL_PAGES:    r_total_pages    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Walk bounds; every walk stops at the top of the tables.
    always_comb begin
        case (i_cmd.walk)
            pfa_pkg::WALK_BASE: limit = clip_pages(r_base_pages);
            pfa_pkg::WALK_HOLE: limit = clip_pages(r_ext_start);
            pfa_pkg::WALK_EXT:  limit = clip_pages(r_total_pages);
            default:            limit = pfa_pkg::CNT_PAGES;
        endcase
    end

    assign walk_end        = (r_cnt >= limit);
    assign step            = (i_cmd.walk != pfa_pkg::WALK_NONE) && !walk_end;
    assign o_stat.walk_end = walk_end;
    assign below_ffe       = (r_cnt < pfa_pkg::t_cnt'(r_first_free_ext));
    assign cnt_page        = pfa_pkg::t_page'(r_cnt);

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.cnt_load) begin
            case (i_cmd.cnt_sel)
                pfa_pkg::CNT_ONE:  n_cnt = pfa_pkg::t_cnt'(1);
                pfa_pkg::CNT_HOLE: n_cnt = pfa_pkg::t_cnt'(r_io_hole_start);
                pfa_pkg::CNT_EXT:  n_cnt = pfa_pkg::t_cnt'(r_ext_start);
                default:           n_cnt = '0;
            endcase
        end else if (step) begin
            n_cnt = r_cnt + pfa_pkg::t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Request capture and table read for a single request.
    assign rd_addr = (i_item.req_type == pfa_pkg::REQ_ALLOC) ?
                     pfa_pkg::t_page'(r_head) :
                     pfa_pkg::t_page'(pfa_pkg::t_cnt'(i_item.page_num));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req     <= i_item.req_type;
            r_pnum    <= i_item.page_num;
            r_zf      <= i_item.zero_fill;
            r_ref_rd  <= ref_mem[rd_addr];
            r_link_rd <= link_mem[rd_addr];
        end
    end

    assign exec_page     = pfa_pkg::t_page'(pfa_pkg::t_cnt'(r_pnum));
    assign head_page     = pfa_pkg::t_page'(r_head);
    assign page_in_range = (pfa_pkg::t_cnt'(r_pnum) < pfa_pkg::CNT_PAGES);
    assign head_empty    = (r_head >= pfa_pkg::LINK_NONE);
    assign linked        = (r_link_rd != pfa_pkg::LINK_NONE);

    always_comb begin
        ref_we   = 1'b0;
        ref_wa   = cnt_page;
        ref_wd   = '0;
        link_we  = 1'b0;
        link_wa  = cnt_page;
        link_wd  = pfa_pkg::LINK_NONE;
        head_we  = 1'b0;
        n_head   = r_head;
        res_we   = 1'b0;
        n_result = '0;

        unique case (i_cmd.walk)
            pfa_pkg::WALK_CLEAR: begin
                if (step) begin
                    ref_we  = 1'b1;
                    ref_wd  = (i_cmd.init_ref0 && r_cnt == '0) ? pfa_pkg::t_ref'(1) : '0;
                    link_we = 1'b1;
                end
            end
            pfa_pkg::WALK_BASE: begin
                if (step) begin
                    link_we = 1'b1;
                    link_wd = r_head;
                    head_we = 1'b1;
                    n_head  = pfa_pkg::t_link'(r_cnt);
                end
            end
            pfa_pkg::WALK_HOLE: begin
                if (step) begin
                    ref_we = 1'b1;
                    ref_wd = pfa_pkg::t_ref'(1);
                end
            end
            pfa_pkg::WALK_EXT: begin
                if (step) begin
                    if (below_ffe) begin
                        ref_we = 1'b1;
                        ref_wd = pfa_pkg::t_ref'(1);
                    end else begin
                        link_we = 1'b1;
                        link_wd = r_head;
                        head_we = 1'b1;
                        n_head  = pfa_pkg::t_link'(r_cnt);
                    end
                end
            end
            default: ;
        endcase

        if (i_cmd.exec) begin
            res_we = 1'b1;
            unique case (r_req) inside
                pfa_pkg::REQ_ALLOC: begin
                    if (head_empty) begin
                        n_result.status = pfa_pkg::STAT_NONE_FREE;
                    end else begin
                        head_we             = 1'b1;
                        n_head              = r_link_rd;
                        link_we             = 1'b1;
                        link_wa             = head_page;
                        link_wd             = pfa_pkg::LINK_NONE;
                        n_result.out_page   = pfa_pkg::t_pnum'(pfa_pkg::t_cnt'(r_head));
                        n_result.ref_after  = pfa_pkg::t_refo'(r_ref_rd);
                        n_result.clear_page = r_zf;
                    end
                end
                pfa_pkg::REQ_FREE, pfa_pkg::REQ_INCREF, pfa_pkg::REQ_DECREF: begin
                    n_result.out_page = r_pnum;
                    if (page_in_range) begin
                        n_result.ref_after = pfa_pkg::t_refo'(r_ref_rd);
                        ref_wa             = exec_page;
                        link_wa            = exec_page;
                        link_wd            = r_head;
                        case (r_req)
                            pfa_pkg::REQ_FREE: begin
                                if (r_ref_rd != '0) begin
                                    n_result.status = pfa_pkg::STAT_REF_NONZERO;
                                end else if (linked) begin
                                    n_result.status = pfa_pkg::STAT_LISTED;
                                end else begin
                                    link_we = 1'b1;
                                    head_we = 1'b1;
                                    n_head  = pfa_pkg::t_link'(exec_page);
                                end
                            end
                            pfa_pkg::REQ_INCREF: begin
                                if (r_ref_rd == pfa_pkg::REF_MAX) begin
                                    n_result.status = pfa_pkg::STAT_SATURATED;
                                end else begin
                                    ref_we             = 1'b1;
                                    ref_wd             = r_ref_rd + pfa_pkg::t_ref'(1);
                                    n_result.ref_after = pfa_pkg::t_refo'(ref_wd);
                                end
                            end
                            default: begin
                                if (r_ref_rd == '0) begin
                                    n_result.status = pfa_pkg::STAT_UNDERFLOW;
                                end else if (r_ref_rd == pfa_pkg::t_ref'(1)) begin
                                    if (linked) begin
                                        n_result.status = pfa_pkg::STAT_LISTED;
                                    end else begin
                                        // Last reference gone: the page goes back on the list.
                                        ref_we             = 1'b1;
                                        ref_wd             = '0;
                                        n_result.ref_after = '0;
                                        link_we            = 1'b1;
                                        head_we            = 1'b1;
                                        n_head             = pfa_pkg::t_link'(exec_page);
                                        n_result.status    = pfa_pkg::STAT_FREED;
                                    end
                                end else begin
                                    ref_we             = 1'b1;
                                    ref_wd             = r_ref_rd - pfa_pkg::t_ref'(1);
                                    n_result.ref_after = pfa_pkg::t_refo'(ref_wd);
                                end
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end

        if (i_cmd.init_done) begin
            res_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ref_we) begin
            ref_mem[ref_wa] <= ref_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= pfa_pkg::LINK_NONE;
        end else if (i_cmd.head_clear) begin
            r_head <= pfa_pkg::LINK_NONE;
        end else if (head_we) begin
            r_head <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= res_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_we) begin
            r_result <= n_result;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

endmodule

### sv/page_frame_allocator.sv
// Top level of the page-frame allocator: controller, datapath and checks.
//
// For alloc, free, incref and decref the request is accepted when start is high
// and busy is low, both tables are read at the page (the list head for alloc) on that
// edge, and the update and the result are registered on the next. The result
// beat (o_result_valid high for one cycle) appears in the cycle after, and a new
// request may be started in that same cycle. An init request clears all NUM_PAGES
// entries one per cycle and then walks the conventional pages, the I/O hole and
// extended memory, one page per cycle each, with busy high throughout and one
// result beat at the end. After reset the block runs the same clearing pass with
// busy high before it takes a request. Configuration writes are taken on any
// cycle, but must only be issued while the block is idle. There is no
// back-pressure on results: a beat is taken the cycle it is shown.
`include "page_frame_allocator_defines.svh"

module page_frame_allocator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  pfa_pkg::t_in_item  i_item,
    input  logic               i_cfg_we,
    input  pfa_pkg::t_cfg_idx  i_cfg_idx,
    input  pfa_pkg::t_cfg      i_cfg_data,
    output logic               o_result_valid,
    output pfa_pkg::t_out_item o_result
);

    pfa_pkg::t_dp_cmd  dp_cmd;
    pfa_pkg::t_dp_stat dp_stat;

    pfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_item.req_type),
        .i_stat     (dp_stat),
        .o_busy     (busy),
        .o_cmd      (dp_cmd)
    );

    pfa_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    `PFA_ASSERT_PROP(a_accept_goes_busy, (start && !busy) |=> busy, "accepted request did not raise busy")
    `PFA_ASSERT_NEVER(a_result_while_busy, o_result_valid && busy, "result beat while busy")
    `PFA_ASSERT_PROP(a_result_single_beat, o_result_valid |=> !o_result_valid, "result beat longer than one cycle")
    `PFA_ASSERT_PROP(a_request_result_timing, (start && !busy && i_item.req_type != pfa_pkg::REQ_INIT) |=> (##1 o_result_valid), "request result not two cycles after accept")

endmodule

### tb/tb_page_frame_allocator.sv
// Self-checking testbench for the page-frame allocator: directed and random requests.
module tb_page_frame_allocator;
    import pfa_pkg::*;

    localparam int     CYCLE_LIMIT   = 3_000_000;
    localparam int     PHASES        = 7;
    localparam int     PHASE_ITEMS   = 136;
    localparam int     REGS          = 5;
    localparam t_req   REQ_LAST_CODE = '1;
    localparam t_pnum  SAT_PAGE      = 15'h2AAA;

    // Frame tables as the block should hold them, plus the results still owed.
    class frame_ledger;
        t_ref      refs  [NUM_PAGES];
        t_link     links [NUM_PAGES];
        t_link     head;
        t_cfg      cfg   [REGS];
        t_out_item due   [$];
        int        errors;

        function new();
            clear_tables();
            cfg[CFG_BASE_PAGES]     = RST_BASE_PAGES;
            cfg[CFG_IO_HOLE_START]  = RST_IO_HOLE_START;
            cfg[CFG_EXT_START]      = RST_EXT_START;
            cfg[CFG_FIRST_FREE_EXT] = RST_FIRST_FREE_EXT;
            cfg[CFG_TOTAL_PAGES]    = RST_TOTAL_PAGES;
            errors = 0;
        endfunction

        function void clear_tables();
            for (int i = 0; i < NUM_PAGES; i++) begin
                refs[i]  = '0;
                links[i] = LINK_NONE;
            end
            head = LINK_NONE;
        endfunction

        function void push_page(int unsigned p);
            links[p] = head;
            head     = t_link'(p);
        endfunction

        function int unsigned clip(t_cfg n);
            return (n > NUM_PAGES) ? NUM_PAGES : n;
        endfunction

        function void rebuild();
            clear_tables();
            refs[0] = t_ref'(1);
            for (int unsigned i = 1; i < clip(cfg[CFG_BASE_PAGES]); i++)
                push_page(i);
            // A hole page that the base walk already listed keeps its link.
            for (int unsigned i = cfg[CFG_IO_HOLE_START]; i < clip(cfg[CFG_EXT_START]); i++)
                refs[i] = t_ref'(1);
            for (int unsigned i = cfg[CFG_EXT_START]; i < clip(cfg[CFG_TOTAL_PAGES]); i++) begin
                if (i < cfg[CFG_FIRST_FREE_EXT])
                    refs[i] = t_ref'(1);
                else
                    push_page(i);
            end
        endfunction

        function t_out_item note_request(t_in_item it);
            t_out_item   r;
            int unsigned p;
            t_ref        cnt;
            logic        linked;
            r      = '0;
            p      = {17'd0, it.page_num};
            cnt    = refs[p];
            linked = (links[p] != LINK_NONE);
            case (it.req_type)
                REQ_INIT: rebuild();
                REQ_ALLOC: begin
                    if (head == LINK_NONE) begin
                        r.status = STAT_NONE_FREE;
                    end else begin
                        p            = {16'd0, head};
                        head         = links[p];
                        links[p]     = LINK_NONE;
                        r.out_page   = t_pnum'(p);
                        r.ref_after  = refs[p];
                        r.clear_page = it.zero_fill;
                    end
                end
                REQ_FREE: begin
                    r.out_page  = it.page_num;
                    r.ref_after = cnt;
                    if (cnt != 0)
                        r.status = STAT_REF_NONZERO;
                    else if (linked)
                        r.status = STAT_LISTED;
                    else
                        push_page(p);
                end
                REQ_INCREF: begin
                    r.out_page  = it.page_num;
                    r.ref_after = cnt;
                    if (cnt == REF_MAX) begin
                        r.status = STAT_SATURATED;
                    end else begin
                        refs[p]     = cnt + 1'b1;
                        r.ref_after = refs[p];
                    end
                end
                REQ_DECREF: begin
                    r.out_page  = it.page_num;
                    r.ref_after = cnt;
                    if (cnt == 0) begin
                        r.status = STAT_UNDERFLOW;
                    end else if (cnt == 1) begin
                        // The link is the only listed mark; a linked page is left alone.
                        if (linked) begin
                            r.status = STAT_LISTED;
                        end else begin
                            refs[p]     = '0;
                            r.ref_after = '0;
                            push_page(p);
                            r.status    = STAT_FREED;
                        end
                    end else begin
                        refs[p]     = cnt - 1'b1;
                        r.ref_after = refs[p];
                    end
                end
                default: ;
            endcase
            due.push_back(r);
            return r;
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: st=%0d pg=%0h ref=%0d clr=%0b",
                             got.status, got.out_page, got.ref_after, got.clear_page);
                return;
            end
            want = due.pop_front();
            if (got.status !== want.status || got.out_page !== want.out_page ||
                got.ref_after !== want.ref_after || got.clear_page !== want.clear_page) begin
                errors++;
                if (errors <= 10) begin
                    $write("mismatch: want st=%0d pg=%0h ref=%0d clr=%0b, ",
                           want.status, want.out_page, want.ref_after, want.clear_page);
                    $display("got st=%0d pg=%0h ref=%0d clr=%0b",
                             got.status, got.out_page, got.ref_after, got.clear_page);
                end
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      i_cfg_we;
    t_cfg_idx  i_cfg_idx;
    t_cfg      i_cfg_data;
    logic      o_result_valid;
    t_out_item o_result;

    frame_ledger ledger = new();
    t_pnum       held [$];
    logic        calm = 1'b0;
    int          cycle_count = 0;

    page_frame_allocator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1)
            ledger.check_result(o_result);
    end

    function automatic t_in_item make_request(t_req kind, t_pnum page, logic fill);
        t_in_item it;
        it.req_type  = kind;
        it.page_num  = page;
        it.zero_fill = fill;
        return it;
    endfunction

    // Holds start high until the request is accepted; start stays high into the next
    // request when no gap follows.
    task automatic send_request(input t_in_item it);
        t_out_item want;
        int        gap;
        int        hit [$];
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        want = ledger.note_request(it);
        if (it.req_type == REQ_ALLOC && want.status == STAT_OK) begin
            held.push_back(want.out_page);
        end else if ((it.req_type == REQ_FREE && want.status == STAT_OK) ||
                     want.status == STAT_FREED) begin
            hit = held.find_first_index(x) with (x == it.page_num);
            if (hit.size() != 0)
                held.delete(hit[0]);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (ledger.due.size() != 0 || busy !== 1'b0);
    endtask

    initial begin
        t_cfg     plan [PHASES][REGS];
        t_in_item it;
        int       roll;

        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_BASE_PAGES;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests on the cleared tables, before any init.
        send_request(make_request(REQ_ALLOC, 15'h0, 1'b1));
        send_request(make_request(REQ_DECREF, 15'h7, 1'b0));
        send_request(make_request(REQ_FREE, 15'h7, 1'b0));
        // The list tail has no link, so a second free pushes it again.
        send_request(make_request(REQ_FREE, 15'h7, 1'b0));
        send_request(make_request(REQ_FREE, 15'h7FFF, 1'b1));
        send_request(make_request(REQ_FREE, 15'h7, 1'b0));
        send_request(make_request(REQ_ALLOC, 15'h7FFF, 1'b1));
        send_request(make_request(REQ_ALLOC, 15'h0, 1'b0));
        send_request(make_request(REQ_ALLOC, 15'h5555, 1'b1));
        send_request(make_request(REQ_ALLOC, 15'h0, 1'b1));
        send_request(make_request(REQ_INCREF, 15'h7FFF, 1'b0));
        send_request(make_request(REQ_INCREF, 15'h7FFF, 1'b0));
        send_request(make_request(REQ_FREE, 15'h7FFF, 1'b0));
        send_request(make_request(REQ_DECREF, 15'h7FFF, 1'b0));
        send_request(make_request(REQ_DECREF, 15'h7FFF, 1'b0));
        send_request(make_request(REQ_DECREF, 15'h7FFF, 1'b0));
        send_request(make_request(REQ_DECREF, 15'h7, 1'b0));
        send_request(make_request(REQ_INCREF, 15'h0, 1'b1));
        for (int r = REQ_INIT + 1; r <= REQ_LAST_CODE; r++)
            send_request(make_request(t_req'(r), 15'h5555, 1'b1));
        send_request(make_request(REQ_INCREF, SAT_PAGE, 1'b0));

        plan[0] = '{RST_BASE_PAGES, RST_IO_HOLE_START, RST_EXT_START, RST_FIRST_FREE_EXT,
                    RST_TOTAL_PAGES};
        plan[1] = '{16'd8, 16'd8, 16'd16, 16'd20, 16'd64};
        plan[2] = '{16'd1, 16'd0, 16'd0, 16'd0, 16'd1};
        plan[3] = '{16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768};
        plan[4] = '{16'd40, 16'd30, 16'd20, 16'd50, 16'd300};
        for (int ph = 5; ph < PHASES; ph++) begin
            plan[ph][CFG_BASE_PAGES]     = t_cfg'($urandom_range(1, 300));
            plan[ph][CFG_IO_HOLE_START]  = t_cfg'($urandom_range(0, 400));
            plan[ph][CFG_EXT_START]      = t_cfg'(plan[ph][CFG_IO_HOLE_START] +
                                                  $urandom_range(0, 200));
            plan[ph][CFG_FIRST_FREE_EXT] = t_cfg'(plan[ph][CFG_EXT_START] +
                                                  $urandom_range(0, 100));
            plan[ph][CFG_TOTAL_PAGES]    = (ph == 5) ? t_cfg'($urandom_range(1, 1200))
                                                     : t_cfg'($urandom_range(16000, 32768));
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            for (int r = CFG_BASE_PAGES; r <= CFG_TOTAL_PAGES; r++) begin
                i_cfg_we   <= 1'b1;
                i_cfg_idx  <= t_cfg_idx'(r);
                i_cfg_data <= plan[ph][r];
                @(posedge i_clk);
                ledger.cfg[r] = plan[ph][r];
            end
            i_cfg_we <= 1'b0;
            held.delete();
            send_request(make_request(REQ_INIT, t_pnum'($urandom_range(0, 32767)),
                                      1'($urandom_range(0, 1))));

            // Mostly alloc / incref / decref / free on pages we hold, with some
            // requests on arbitrary pages and a few unused codes as noise.
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 20 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                it = make_request(REQ_ALLOC, t_pnum'($urandom_range(0, 32767)),
                                  1'($urandom_range(0, 1)));
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    it.req_type = t_req'($urandom_range(REQ_INIT + 1, REQ_LAST_CODE));
                end else if (roll < 30 || held.size() == 0) begin
                    it.req_type = REQ_ALLOC;
                end else if (roll < 85) begin
                    it.page_num = held[$urandom_range(0, held.size() - 1)];
                    roll = $urandom_range(0, 99);
                    it.req_type = (roll < 35) ? REQ_INCREF : (roll < 80) ? REQ_DECREF : REQ_FREE;
                end else begin
                    it.req_type = t_req'($urandom_range(REQ_FREE, REQ_DECREF));
                end
                send_request(it);
            end
            calm = 1'b0;
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (ledger.due.size() != 0) begin
            $display("%0d expected results never arrived", ledger.due.size());
            ledger.errors++;
        end
        if (ledger.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
